// ===== src/layered_key_color_compositor_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef LAYERED_KEY_COLOR_COMPOSITOR_UNIT_DEFINES_SVH
`define LAYERED_KEY_COLOR_COMPOSITOR_UNIT_DEFINES_SVH

// checked only while out of reset
`define LKCC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LKCC_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lkcc_pkg.sv =====
// shared types and constants for the layered key color compositor
`timescale 1ns / 1ps

package lkcc_pkg;

    localparam int KEYS_DEF       = 128;
    localparam int MAX_LAYERS_DEF = 8;
    localparam int COLOR_W        = 24;
    localparam int ENTRY_W        = COLOR_W + 1;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 24'hFF0000;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         key_index;
        logic [7:0]         layer_index;
        logic [COLOR_W-1:0] color_rgb;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_out;
        logic               color_active;
        status_t            status;
    } result_t;

endpackage

// ===== src/layered_key_color_compositor_unit.sv =====
// layered key color compositor: top level with output register
`timescale 1ns / 1ps

// Per-key color store with stacked layers, one request in and one result out per transaction.
// Input channel s_*: tuser carries req_type (set, clear, lookup); tdata carries key, layer
// and color. Output channel m_*: tdata carries the color found, tuser the active flag and
// the status code.
// Requests are taken one at a time. A set or clear (or any ignored request) passes from
// acceptance through the execute state into the output register, waiting in that state
// while the output register is held; a lookup that visits n layers (1 to MAX_LAYERS) does
// one entry memory read per layer, pipelined so a new layer is read every cycle. The next
// request is accepted the cycle after the result is registered.
// After reset the block writes every entry of the store once (layer 0 active red, all
// others inactive) and holds s_tready low until that is done.
// Two layers are in use after reset.
// A stalled receiver holds the result in the output register; one more request may be
// taken meanwhile, and its result waits in the sequencer until the register frees up.
module layered_key_color_compositor_unit #(
    parameter int KEYS       = lkcc_pkg::KEYS_DEF,
    parameter int MAX_LAYERS = lkcc_pkg::MAX_LAYERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key_index[7:0], layer_index[15:8], color_rgb[39:16]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // color_out[23:0]
    output logic [2:0]  m_tuser    // color_active[0], status[2:1]
);

    import lkcc_pkg::*;

    localparam int DEPTH = KEYS * MAX_LAYERS;
    localparam int AW    = $clog2(DEPTH);

    item_t              item;
    result_t            res;
    logic               res_valid;
    logic               res_ready;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    assign item.req_type    = s_tuser;
    assign item.key_index   = s_tdata[7:0];
    assign item.layer_index = s_tdata[15:8];
    assign item.color_rgb   = s_tdata[39:16];

    lkcc_core #(
        .KEYS       (KEYS),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lkcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.color_out;
    assign m_tuser  = {out_reg.status, out_reg.color_active};

endmodule

// ===== src/lkcc_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lkcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lkcc_core.sv =====
// request sequencer: clearing pass, set and clear writes, downward lookup scan
`timescale 1ns / 1ps

module lkcc_core #(
    parameter int KEYS       = lkcc_pkg::KEYS_DEF,
    parameter int MAX_LAYERS = lkcc_pkg::MAX_LAYERS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  lkcc_pkg::item_t                       item,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output lkcc_pkg::result_t                     res,
    output logic                                  mem_we,
    output logic [$clog2(KEYS*MAX_LAYERS)-1:0]    mem_waddr,
    output logic [lkcc_pkg::ENTRY_W-1:0]          mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(KEYS*MAX_LAYERS)-1:0]    mem_raddr,
    input  logic [lkcc_pkg::ENTRY_W-1:0]          mem_rdata
);

    import lkcc_pkg::*;

    localparam int DEPTH = KEYS * MAX_LAYERS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_LAYERS);
    localparam int CW    = $clog2(MAX_LAYERS + 1);

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [CW-1:0]   inuse_reg, inuse_next;
    logic [LW-1:0]   cur_reg, cur_next;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;
    logic [AW-1:0]   clr_reg, clr_next;

    logic            key_ok;
    logic            layer_ok;
    logic            full;
    logic [LW-1:0]   top_layer;
    logic [LW-1:0]   set_layer;
    logic            hit;

    function automatic logic [AW-1:0] slot(input logic [LW-1:0] l, input logic [7:0] k);
        slot = AW'(l) * AW'(KEYS) + AW'(k);
    endfunction

    assign key_ok    = {1'b0, item_reg.key_index} < 9'(KEYS);
    assign layer_ok  = {1'b0, item_reg.layer_index} < 9'(inuse_reg);
    assign full      = inuse_reg == CW'(MAX_LAYERS);
    assign top_layer = LW'(inuse_reg - CW'(1));
    // a set above the top lands on the next layer up, unless the stack is full
    assign set_layer = layer_ok ? LW'(item_reg.layer_index) : LW'(inuse_reg);
    assign hit       = pend_reg && mem_rdata[ENTRY_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            inuse_reg     <= CW'(2);
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            inuse_reg     <= inuse_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cur_reg  <= cur_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        inuse_next     = inuse_reg;
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        clr_next       = clr_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        res            = '{color_out: '0, color_active: 1'b0, status: ST_DONE};
        mem_we         = 1'b0;
        mem_waddr      = slot(set_layer, item_reg.key_index);
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = slot(cur_reg, item_reg.key_index);

        case (state_reg)
            S_CLR:
            begin
                // one entry per cycle: layer 0 gets active red, the rest inactive
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg < AW'(KEYS)) ? {1'b1, RESET_COLOR} : '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_valid = 1'b1;
                if (!key_ok)
                begin
                    res.status = ST_IGNORED;
                end
                else
                begin
                    case (item_reg.req_type)
                        REQ_SET:
                        begin
                            if (!layer_ok && full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = res_ready;
                                mem_wdata = {1'b1, item_reg.color_rgb};
                                if (!layer_ok && res_ready)
                                begin
                                    inuse_next = inuse_reg + CW'(1);
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            if (!layer_ok)
                            begin
                                res.status = ST_IGNORED;
                            end
                            else
                            begin
                                mem_we = res_ready;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            res_valid      = 1'b0;
                            cur_next       = layer_ok ? LW'(item_reg.layer_index) : top_layer;
                            pend_next      = 1'b0;
                            pend_last_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            res.status = ST_IGNORED;
                        end
                    endcase
                end
                if (res_valid && res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (hit || (pend_reg && pend_last_reg))
                begin
                    // read data holds while the result waits for a free slot
                    res_valid          = 1'b1;
                    res.color_active   = hit;
                    res.color_out      = hit ? mem_rdata[COLOR_W-1:0] : '0;
                    if (res_ready)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // one read per cycle, checked on the next
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = cur_reg == '0;
                    cur_next       = cur_reg - LW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lkcc_checker.sv =====
// port-level checks for the compositor, bound to the top level
`timescale 1ns / 1ps

`include "layered_key_color_compositor_unit_defines.svh"

module lkcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    import lkcc_pkg::*;

    // a stalled result stays put
    `LKCC_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // requests are handled one at a time
    `LKCC_CHECK(a_one_request, s_tvalid && s_tready |=> !s_tready, "request accepted while one is in work")

    // a found color always reports done; anything else carries color 0
    `LKCC_CHECK(a_result_fields, m_tvalid |-> (m_tuser[0] ? (m_tuser[2:1] == ST_DONE) : (m_tdata == 24'd0)) && (m_tuser[2:1] == ST_DONE || m_tuser[2:1] == ST_IGNORED || m_tuser[2:1] == ST_FULL), "inconsistent result fields")

    // store clearing pass runs right after reset
    `LKCC_CHECK_ALWAYS(a_clear_after_reset, $rose(rst_n) |-> !s_tready && !m_tvalid, "block ready before the store was cleared")

endmodule

bind layered_key_color_compositor_unit lkcc_checker u_lkcc_checker (.*);

// ===== tb/layered_key_color_compositor_unit_test.sv =====
// self-checking testbench for the layered key color compositor
`timescale 1ns / 1ps

module layered_key_color_compositor_unit_test;

    import lkcc_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 375;
    localparam int QUIET_FROM   = 320;
    localparam int N_DIRECTED   = 27;

    typedef struct packed {
        item_t   stim;
        bit      fixed;
        result_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // key_index[7:0], layer_index[15:8], color_rgb[39:16]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // color_out[23:0]
    logic [2:0]  m_tuser;        // color_active[0], status[2:1]

    // shadow copy of the layer stack, bit 24 is the active mark
    logic [ENTRY_W-1:0] shadow_store [MAX_LAYERS_DEF][KEYS_DEF];
    int                 shadow_layers;

    result_t       pending_results [$];
    directed_row_t directed_rows [N_DIRECTED];
    int            fail_count = 0;
    int            results_seen = 0;
    bit            quiet_phase = 1'b0;
    bit            hold_off = 1'b0;

    layered_key_color_compositor_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // updates the shadow stack and works out the answer to one request
    task automatic apply_request(input item_t it, output result_t res);
        int top;
        int l;
        res = '{COLOR_W'(0), 1'b0, ST_DONE};
        if (it.req_type == REQ_UNKNOWN || it.key_index >= KEYS_DEF)
        begin
            res.status = ST_IGNORED;
            return;
        end
        case (it.req_type)
            REQ_SET:
            begin
                if (it.layer_index < shadow_layers)
                    shadow_store[it.layer_index][it.key_index] = {1'b1, it.color_rgb};
                else if (shadow_layers >= MAX_LAYERS_DEF)
                    res.status = ST_FULL;
                else
                begin
                    // new layer goes right above the top, whatever layer was asked for
                    for (int k = 0; k < KEYS_DEF; k++)
                        shadow_store[shadow_layers][k] = '0;
                    shadow_store[shadow_layers][it.key_index] = {1'b1, it.color_rgb};
                    shadow_layers++;
                end
            end
            REQ_CLEAR:
            begin
                if (it.layer_index >= shadow_layers)
                    res.status = ST_IGNORED;
                else
                    shadow_store[it.layer_index][it.key_index] = '0;
            end
            default:
            begin
                top = (it.layer_index >= shadow_layers) ? shadow_layers - 1 : it.layer_index;
                for (l = top; l >= 0; l--)
                begin
                    if (shadow_store[l][it.key_index][COLOR_W])
                    begin
                        res.color_out    = shadow_store[l][it.key_index][COLOR_W-1:0];
                        res.color_active = 1'b1;
                        return;
                    end
                end
            end
        endcase
    endtask

    task automatic drive_request(input item_t it, input bit fixed, input result_t want);
        result_t predicted;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {it.color_rgb, it.layer_index, it.key_index};
        do @(posedge clk); while (!s_tready);
        apply_request(it, predicted);
        pending_results.insert(pending_results.size(), fixed ? want : predicted);
    endtask

    // long receiver hold-off so the block fills up and stalls its input
    initial
    begin
        wait (results_seen >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : result_sink
        int      stall_left;
        result_t got;
        result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                got.color_out    = m_tdata;
                got.color_active = m_tuser[0];
                got.status       = status_t'(m_tuser[2:1]);
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: color %h active %b status %0d",
                                 got.color_out, got.color_active, got.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.color_out !== want.color_out
                        || got.color_active !== want.color_active
                        || got.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected color %h active %b status %0d, %s",
                                     want.color_out, want.color_active, want.status,
                                     $sformatf("got color %h active %b status %0d",
                                               got.color_out, got.color_active, got.status));
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
            m_tready <= (stall_left == 0) && !hold_off;
        end
    end

    initial
    begin : stimulus
        item_t   it;
        result_t none;
        int      sel;
        none = '{COLOR_W'(0), 1'b0, ST_DONE};
        for (int l = 0; l < MAX_LAYERS_DEF; l++)
            for (int k = 0; k < KEYS_DEF; k++)
                shadow_store[l][k] = (l == 0) ? {1'b1, RESET_COLOR} : '0;
        shadow_layers = 2;

        directed_rows = '{
            '{'{REQ_LOOKUP, 8'd0, 8'd255, 24'h0}, 1'b1, '{24'hFF0000, 1'b1, ST_DONE}},
            '{'{REQ_LOOKUP, 8'd127, 8'd0, 24'h0}, 1'b1, '{24'hFF0000, 1'b1, ST_DONE}},
            '{'{REQ_SET, 8'd128, 8'd0, 24'h123456}, 1'b1, '{24'h0, 1'b0, ST_IGNORED}},
            '{'{REQ_LOOKUP, 8'd255, 8'd255, 24'h0}, 1'b1, '{24'h0, 1'b0, ST_IGNORED}},
            '{'{REQ_UNKNOWN, 8'd0, 8'd0, 24'hFFFFFF}, 1'b1, '{24'h0, 1'b0, ST_IGNORED}},
            // clear above the top layer in use
            '{'{REQ_CLEAR, 8'd0, 8'd2, 24'h0}, 1'b1, '{24'h0, 1'b0, ST_IGNORED}},
            '{'{REQ_CLEAR, 8'd3, 8'd255, 24'h0}, 1'b1, '{24'h0, 1'b0, ST_IGNORED}},
            '{'{REQ_SET, 8'd0, 8'd1, 24'hFFFFFF}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_LOOKUP, 8'd0, 8'd1, 24'h0}, 1'b0, none},
            '{'{REQ_SET, 8'd1, 8'd1, 24'h000000}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_LOOKUP, 8'd1, 8'd255, 24'h0}, 1'b0, none},
            '{'{REQ_CLEAR, 8'd0, 8'd0, 24'h0}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_CLEAR, 8'd0, 8'd1, 24'h0}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            // nothing active left for key 0
            '{'{REQ_LOOKUP, 8'd0, 8'd7, 24'h0}, 1'b0, none},
            // sets above the top open one layer each until the stack is full
            '{'{REQ_SET, 8'd2, 8'd255, 24'h00FF00}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_LOOKUP, 8'd2, 8'd255, 24'h0}, 1'b0, none},
            '{'{REQ_LOOKUP, 8'd3, 8'd2, 24'h0}, 1'b0, none},
            '{'{REQ_SET, 8'd127, 8'd100, 24'h0000FF}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_SET, 8'd4, 8'd4, 24'hA5A5A5}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_SET, 8'd5, 8'd200, 24'h5A5A5A}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_SET, 8'd6, 8'd6, 24'hC0FFEE}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_SET, 8'd7, 8'd255, 24'h800001}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_SET, 8'd8, 8'd8, 24'h123456}, 1'b1, '{24'h0, 1'b0, ST_FULL}},
            '{'{REQ_LOOKUP, 8'd127, 8'd255, 24'h0}, 1'b0, none},
            '{'{REQ_LOOKUP, 8'd7, 8'd7, 24'h0}, 1'b0, none},
            '{'{REQ_CLEAR, 8'd7, 8'd7, 24'h0}, 1'b1, '{24'h0, 1'b0, ST_DONE}},
            '{'{REQ_LOOKUP, 8'd7, 8'd255, 24'h0}, 1'b0, none}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            drive_request(directed_rows[i].stim, directed_rows[i].fixed,
                          directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            it.req_type = (sel < 35) ? REQ_SET : (sel < 60) ? REQ_CLEAR :
                          (sel < 95) ? REQ_LOOKUP : REQ_UNKNOWN;
            // mostly a few keys and the real layers, so lookups hit written entries
            sel = $urandom_range(0, 9);
            it.key_index = (sel < 8) ? 8'($urandom_range(0, 15)) :
                           (sel == 8) ? 8'($urandom_range(0, KEYS_DEF - 1)) :
                           8'($urandom_range(0, 255));
            sel = $urandom_range(0, 9);
            it.layer_index = (sel < 8) ? 8'($urandom_range(0, MAX_LAYERS_DEF + 1)) :
                             8'($urandom_range(0, 255));
            it.color_rgb = 24'($urandom);
            drive_request(it, 1'b0, none);
            if (n == QUIET_FROM)
                quiet_phase <= 1'b1;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
